// File: rtl/quaternion_vertex_projection_defines.svh
// Assertion macros for the checker module.
`ifndef QUATERNION_VERTEX_PROJECTION_DEFINES_SVH
`define QUATERNION_VERTEX_PROJECTION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QVP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QVP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/qvp_pkg.sv
package qvp_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int OFF_SHIFT      = 2 * QUAT_FRAC_BITS - 8;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ROT_W      = 3'd0;
    localparam logic [2:0] REG_ROT_X      = 3'd1;
    localparam logic [2:0] REG_ROT_Y      = 3'd2;
    localparam logic [2:0] REG_ROT_Z      = 3'd3;
    localparam logic [2:0] REG_OFFSET_X   = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd5;
    localparam logic [2:0] REG_OFFSET_Z   = 3'd6;
    localparam logic [2:0] REG_PROJ_SCALE = 3'd7;

    localparam int VW  = 8;    // vertex coordinate
    localparam int MVW = 24;   // q times v
    localparam int PW  = 26;   // first quaternion product
    localparam int PQW = 42;   // p times q
    localparam int TW  = 45;   // translated point, signed
    localparam int MW  = 44;   // magnitude of the translated point
    localparam int LOW = 22;   // low slice of a magnitude for the scale multiply
    localparam int SPW = 38;   // scale times one slice
    localparam int NW  = 52;   // numerator after dropping the 256 of the divisor
    localparam int QB  = 8;    // quotient bits
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic signed [15:0] rot_w;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_z;
        logic [15:0]        proj_scale;
    } qvp_cfg_t;

    // Classified point handed from the rotation part to the projection part.
    typedef struct packed {
        logic [MW-1:0] mag_x;
        logic [MW-1:0] mag_y;
        logic [MW-1:0] den;
        logic          neg_x;
        logic          neg_y;
        logic          dz;
    } qvp_entry_t;

endpackage

// File: rtl/quaternion_vertex_projection.sv
// Quaternion vertex projection.
// Input channel s_*: one model vertex per request, tdata = {vertex_z, vertex_y, vertex_x}.
// Output channel m_*: one projected point per vertex, in the same order,
//   tdata = {proj_y, proj_x}, tuser = {depth_zero, saturated}.
// Configuration: cfg_wr_en, cfg_addr and cfg_wdata write the rotation quaternion,
//   the offset and the projection scale; write them only while no vertex is in flight.
// Throughput is one vertex per cycle while the output is taken at once. A vertex
//   passes through five rotation stages, the queue, and twelve projection stages
//   (two for the scale multiply, one overflow check, eight restoring divider steps
//   and the output register).
// A four-entry queue separates the rotation and projection pipelines, so s_tready
//   depends only on the queue filling and the last rotation stage, not on m_tready.
// When the receiver stalls the output holds, the projection pipeline freezes, and
//   the rotation pipeline keeps running until the queue is full.
// Reset (aresetn low, synchronous) empties both pipelines and the queue and
//   loads the default configuration.
module quaternion_vertex_projection
    import qvp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // vertex_x, vertex_y, vertex_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // proj_x, proj_y
    output logic [1:0]  m_tuser    // saturated, depth_zero
);

    qvp_cfg_t   cfg_reg;
    qvp_entry_t push_entry, head;
    logic       push, pop, full, empty;
    logic signed [7:0] proj_x, proj_y;
    logic       saturated, depth_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rot_w      <= 16'sd4240;
            cfg_reg.rot_x      <= 16'sd15826;
            cfg_reg.rot_y      <= '0;
            cfg_reg.rot_z      <= '0;
            cfg_reg.offset_x   <= '0;
            cfg_reg.offset_y   <= '0;
            cfg_reg.offset_z   <= 16'sd17920;
            cfg_reg.proj_scale <= 16'd18204;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ROT_W:      cfg_reg.rot_w      <= cfg_wdata;
                REG_ROT_X:      cfg_reg.rot_x      <= cfg_wdata;
                REG_ROT_Y:      cfg_reg.rot_y      <= cfg_wdata;
                REG_ROT_Z:      cfg_reg.rot_z      <= cfg_wdata;
                REG_OFFSET_X:   cfg_reg.offset_x   <= cfg_wdata;
                REG_OFFSET_Y:   cfg_reg.offset_y   <= cfg_wdata;
                REG_OFFSET_Z:   cfg_reg.offset_z   <= cfg_wdata;
                REG_PROJ_SCALE: cfg_reg.proj_scale <= cfg_wdata;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    qvp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .vx         (s_tdata[7:0]),
        .vy         (s_tdata[15:8]),
        .vz         (s_tdata[23:16]),
        .fifo_full  (full),
        .push       (push),
        .push_entry (push_entry)
    );

    qvp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    qvp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .proj_scale (cfg_reg.proj_scale),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .proj_x     (proj_x),
        .proj_y     (proj_y),
        .saturated  (saturated),
        .depth_zero (depth_zero)
    );

    assign m_tdata = {proj_y, proj_x};
    assign m_tuser = {depth_zero, saturated};

endmodule

// File: rtl/qvp_front.sv
module qvp_front
    import qvp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qvp_cfg_t              cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [VW-1:0]  vx,
    input  logic signed [VW-1:0]  vy,
    input  logic signed [VW-1:0]  vz,
    input  logic                  fifo_full,
    output logic                  push,
    output qvp_entry_t            push_entry
);

    logic [4:0] fv_reg;
    logic       fe_adv;

    logic signed [MVW-1:0] mv_reg [12];
    logic signed [PW-1:0]  p_reg [4];
    logic signed [PW-1:0]  p_next [4];
    logic signed [PQW-1:0] pq_reg [12];
    logic signed [TW-1:0]  t_reg [3];
    logic signed [TW-1:0]  t_next [3];
    qvp_entry_t            ent_reg;
    qvp_entry_t            ent_next;

    assign fe_adv   = !fv_reg[4] || !fifo_full;
    assign in_ready = fe_adv;
    assign push     = fv_reg[4] && !fifo_full;
    assign push_entry = ent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (fe_adv) begin
            fv_reg <= {fv_reg[3:0], in_valid};
        end
    end

    always_comb begin
        p_next[0] = -PW'(mv_reg[0]) - PW'(mv_reg[1]) - PW'(mv_reg[2]);
        p_next[1] =  PW'(mv_reg[3]) + PW'(mv_reg[4]) - PW'(mv_reg[5]);
        p_next[2] =  PW'(mv_reg[6]) - PW'(mv_reg[7]) + PW'(mv_reg[8]);
        p_next[3] =  PW'(mv_reg[9]) + PW'(mv_reg[10]) - PW'(mv_reg[11]);
        t_next[0] = -TW'(pq_reg[0]) + TW'(pq_reg[1]) - TW'(pq_reg[2]) + TW'(pq_reg[3])
                    + (TW'(cfg.offset_x) <<< OFF_SHIFT);
        t_next[1] = -TW'(pq_reg[4]) + TW'(pq_reg[5]) + TW'(pq_reg[6]) - TW'(pq_reg[7])
                    + (TW'(cfg.offset_y) <<< OFF_SHIFT);
        t_next[2] = -TW'(pq_reg[8]) - TW'(pq_reg[9]) + TW'(pq_reg[10]) + TW'(pq_reg[11])
                    + (TW'(cfg.offset_z) <<< OFF_SHIFT);
        // The divisor is -tz, so a positive depth flips the quotient sign.
        ent_next.mag_x = MW'(t_reg[0][TW-1] ? -t_reg[0] : t_reg[0]);
        ent_next.mag_y = MW'(t_reg[1][TW-1] ? -t_reg[1] : t_reg[1]);
        ent_next.den   = MW'(t_reg[2][TW-1] ? -t_reg[2] : t_reg[2]);
        ent_next.dz    = (t_reg[2] == '0);
        ent_next.neg_x = t_reg[0][TW-1] ^ !t_reg[2][TW-1];
        ent_next.neg_y = t_reg[1][TW-1] ^ !t_reg[2][TW-1];
    end

    always_ff @(posedge aclk) begin
        if (fe_adv) begin
            mv_reg[0]  <= MVW'(cfg.rot_x) * MVW'(vx);
            mv_reg[1]  <= MVW'(cfg.rot_y) * MVW'(vy);
            mv_reg[2]  <= MVW'(cfg.rot_z) * MVW'(vz);
            mv_reg[3]  <= MVW'(cfg.rot_w) * MVW'(vx);
            mv_reg[4]  <= MVW'(cfg.rot_y) * MVW'(vz);
            mv_reg[5]  <= MVW'(cfg.rot_z) * MVW'(vy);
            mv_reg[6]  <= MVW'(cfg.rot_w) * MVW'(vy);
            mv_reg[7]  <= MVW'(cfg.rot_x) * MVW'(vz);
            mv_reg[8]  <= MVW'(cfg.rot_z) * MVW'(vx);
            mv_reg[9]  <= MVW'(cfg.rot_w) * MVW'(vz);
            mv_reg[10] <= MVW'(cfg.rot_x) * MVW'(vy);
            mv_reg[11] <= MVW'(cfg.rot_y) * MVW'(vx);
            p_reg      <= p_next;
            pq_reg[0]  <= PQW'(p_reg[0]) * PQW'(cfg.rot_x);
            pq_reg[1]  <= PQW'(p_reg[1]) * PQW'(cfg.rot_w);
            pq_reg[2]  <= PQW'(p_reg[2]) * PQW'(cfg.rot_z);
            pq_reg[3]  <= PQW'(p_reg[3]) * PQW'(cfg.rot_y);
            pq_reg[4]  <= PQW'(p_reg[0]) * PQW'(cfg.rot_y);
            pq_reg[5]  <= PQW'(p_reg[1]) * PQW'(cfg.rot_z);
            pq_reg[6]  <= PQW'(p_reg[2]) * PQW'(cfg.rot_w);
            pq_reg[7]  <= PQW'(p_reg[3]) * PQW'(cfg.rot_x);
            pq_reg[8]  <= PQW'(p_reg[0]) * PQW'(cfg.rot_z);
            pq_reg[9]  <= PQW'(p_reg[1]) * PQW'(cfg.rot_y);
            pq_reg[10] <= PQW'(p_reg[2]) * PQW'(cfg.rot_x);
            pq_reg[11] <= PQW'(p_reg[3]) * PQW'(cfg.rot_w);
            t_reg      <= t_next;
            ent_reg    <= ent_next;
        end
    end

endmodule

// File: rtl/qvp_fifo.sv
module qvp_fifo
    import qvp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  qvp_entry_t push_entry,
    input  logic       pop,
    output qvp_entry_t head,
    output logic       full,
    output logic       empty
);

    qvp_entry_t           mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;

    assign full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !(pop && !empty)) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop && !empty) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/qvp_back.sv
module qvp_back
    import qvp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          proj_scale,
    input  qvp_entry_t           head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [7:0]    proj_x,
    output logic signed [7:0]    proj_y,
    output logic                 saturated,
    output logic                 depth_zero
);

    localparam int NSTG = QB + 4;

    logic [NSTG-1:0] bv_reg;
    logic            be_adv;

    logic [SPW-1:0]  lo_reg [2];
    logic [SPW-1:0]  hi_reg [2];
    logic [NW-1:0]   n_reg [2];
    logic [MW-1:0]   den_reg [QB+3];
    logic            dz_reg [QB+3];
    logic            neg_reg [QB+3][2];

    logic [NW-1:0]   rem_reg [QB+1][2];
    logic [QB-1:0]   quo_reg [QB+1][2];
    logic            ovf_reg [QB+1][2];

    logic [NW:0]     dsh [QB];
    logic            ge [QB][2];
    logic [NW-1:0]   rem_next [QB][2];

    logic signed [7:0] px_reg, py_reg;
    logic              sat_reg, dz_out_reg;
    logic signed [7:0] res [2];
    logic              sat_l [2];

    assign be_adv    = !bv_reg[NSTG-1] || out_ready;
    assign pop       = be_adv;
    assign out_valid = bv_reg[NSTG-1];
    assign proj_x    = px_reg;
    assign proj_y    = py_reg;
    assign saturated = sat_reg;
    assign depth_zero = dz_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= '0;
        end else if (be_adv) begin
            bv_reg <= {bv_reg[NSTG-2:0], !empty};
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            dsh[k] = (NW+1)'(den_reg[k+2]) << (QB - 1 - k);
            for (int l = 0; l < 2; l++) begin
                ge[k][l] = ({1'b0, rem_reg[k][l]} >= dsh[k]);
                rem_next[k][l] = ge[k][l] ? NW'({1'b0, rem_reg[k][l]} - dsh[k])
                                          : rem_reg[k][l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            sat_l[l] = 1'b0;
            if (neg_reg[QB+2][l]) begin
                if (ovf_reg[QB][l] || (quo_reg[QB][l] > 8'd128)) begin
                    res[l]   = -8'sd128;
                    sat_l[l] = 1'b1;
                end else begin
                    res[l] = 8'(-{1'b0, quo_reg[QB][l]});
                end
            end else begin
                if (ovf_reg[QB][l] || quo_reg[QB][l][QB-1]) begin
                    res[l]   = 8'sd127;
                    sat_l[l] = 1'b1;
                end else begin
                    res[l] = 8'(quo_reg[QB][l]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (be_adv) begin
            lo_reg[0]     <= SPW'(proj_scale) * SPW'(head.mag_x[LOW-1:0]);
            hi_reg[0]     <= SPW'(proj_scale) * SPW'(head.mag_x[MW-1:LOW]);
            lo_reg[1]     <= SPW'(proj_scale) * SPW'(head.mag_y[LOW-1:0]);
            hi_reg[1]     <= SPW'(proj_scale) * SPW'(head.mag_y[MW-1:LOW]);
            den_reg[0]    <= head.den;
            dz_reg[0]     <= head.dz;
            neg_reg[0][0] <= head.neg_x;
            neg_reg[0][1] <= head.neg_y;
            for (int s = 1; s < QB + 3; s++) begin
                den_reg[s] <= den_reg[s-1];
                dz_reg[s]  <= dz_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
            for (int l = 0; l < 2; l++) begin
                // The 256 of the divisor is dropped from the numerator first.
                n_reg[l] <= NW'(((NW+8)'(lo_reg[l]) + ((NW+8)'(hi_reg[l]) << LOW)) >> 8);
                rem_reg[0][l] <= n_reg[l];
                quo_reg[0][l] <= '0;
                ovf_reg[0][l] <= ({1'b0, n_reg[l]} >= ((NW+1)'(den_reg[1]) << QB));
                for (int k = 0; k < QB; k++) begin
                    rem_reg[k+1][l] <= rem_next[k][l];
                    quo_reg[k+1][l] <= {quo_reg[k][l][QB-2:0], ge[k][l]};
                    ovf_reg[k+1][l] <= ovf_reg[k][l];
                end
            end
            if (dz_reg[QB+2]) begin
                px_reg  <= '0;
                py_reg  <= '0;
                sat_reg <= 1'b0;
            end else begin
                px_reg  <= res[0];
                py_reg  <= res[1];
                sat_reg <= sat_l[0] || sat_l[1];
            end
            dz_out_reg <= dz_reg[QB+2];
        end
    end

endmodule

// File: rtl/qvp_checker.sv
`include "quaternion_vertex_projection_defines.svh"

module qvp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `QVP_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `QVP_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `QVP_ASSERT_NOW(a_zero_depth, aclk, aresetn, m_tvalid && m_tuser[1], m_tdata == 16'h0000 && !m_tuser[0], "zero depth must give zeros")
    `QVP_ASSERT_NOW(a_sat_rail, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'h7f || m_tdata[7:0] == 8'h80 || m_tdata[15:8] == 8'h7f || m_tdata[15:8] == 8'h80, "saturation without a clamped value")

endmodule

bind quaternion_vertex_projection qvp_checker u_qvp_checker (.*);
